// File: src/smf_pkg.sv
// smf_pkg: shared constants and types of the sliding median filter
// no dependencies; imported by the interfaces and every module of the block
package smf_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int INDEX_W  = 12;
  localparam int HW_W     = 3;

  // parameter defaults
  localparam int WINDOW_MAX_DEF = 11;
  localparam int LINE_MAX_DEF   = 4096;

  // half width after reset (11-tap median window)
  localparam logic [HW_W-1:0] HW_RESET = 3'd5;

  // job queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // per-job control travelling with the window snapshot
  typedef struct packed {
    logic [HW_W-1:0]    half;
    logic [INDEX_W-1:0] center;
  } smf_ctl_t;

endpackage

// File: src/smf_in_if.sv
// smf_in_if: sample input channel (valid, ready, sample, line_start)
// depends on smf_pkg for the field widths
interface smf_in_if import smf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                line_start;

  modport source (output valid, output sample, output line_start, input ready);
  modport sink   (input valid, input sample, input line_start, output ready);
endinterface

// File: src/smf_out_if.sv
// smf_out_if: result channel (valid, ready, median_value, center_index)
// depends on smf_pkg for the field widths
interface smf_out_if import smf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] median_value;
  logic [INDEX_W-1:0]  center_index;

  modport source (output valid, output median_value, output center_index, input ready);
  modport sink   (input valid, input median_value, input center_index, output ready);
endinterface

// File: src/sliding_median_filter_core.sv
// sliding_median_filter_core: top level of the running median filter
// depends on smf_pkg, smf_in_if, smf_out_if, smf_front, smf_job_queue, smf_back
//
//   port       dir   transaction / contents
//   in_ch      sink  sample (32b), line_start (1b)
//   out_ch     src   median_value (32b), center_index (12b)
//   cfg_we/wd  in    half_width write, 3b, no read-back
//
// one sample accepted per cycle while in_ch.ready is high; a result is registered in turn in
// the queue entry, the comparison-matrix stage and the rank-select output register
// synchronous active-low reset clears fill count, position, queue and valids;
// half width returns to 5
// a stalled output fills the two-entry job queue, then in_ch.ready drops
module sliding_median_filter_core import smf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int LINE_MAX   = LINE_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [HW_W-1:0]  cfg_wdata,
  smf_in_if.sink           in_ch,
  smf_out_if.source        out_ch
);

  localparam int WIN_BITS = WINDOW_MAX * SAMPLE_W;
  localparam int JOB_W    = WIN_BITS + $bits(smf_ctl_t);

  logic                                q_full, q_empty, q_push, q_pop;
  logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] f_win, b_win;
  smf_ctl_t                            f_ctl, b_ctl;
  logic [JOB_W-1:0]                    q_head;

  // front: window and classification
  smf_front #(
    .WINDOW_MAX(WINDOW_MAX),
    .LINE_MAX  (LINE_MAX)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_sample    (in_ch.sample),
    .in_line_start(in_ch.line_start),
    .q_full       (q_full),
    .q_push       (q_push),
    .job_win      (f_win),
    .job_ctl      (f_ctl)
  );

  // job queue
  smf_job_queue #(
    .DATA_W(JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_ctl, f_win}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_head),
    .empty    (q_empty)
  );

  assign b_win = q_head[WIN_BITS-1:0];
  assign b_ctl = q_head[JOB_W-1:WIN_BITS];

  // back: median selection and output register
  smf_back #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .job_win   (b_win),
    .job_ctl   (b_ctl),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_median(out_ch.median_value),
    .out_center(out_ch.center_index)
  );

  // the front never pushes into a full queue; ready follows queue space
  a_ready_space: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == !q_full)
    else $error("input ready out of step with queue space");
  a_push_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_ch.valid && in_ch.ready))
    else $error("job pushed without an input transaction");

endmodule

// File: src/smf_front.sv
// smf_front: takes samples in, keeps the window, fill count and line position,
// and decides which samples produce a median job; depends on smf_pkg
module smf_front import smf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter int LINE_MAX   = LINE_MAX_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [HW_W-1:0]                      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_W-1:0]                  in_sample,
  input  logic                                 in_line_start,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [WINDOW_MAX-1:0][SAMPLE_W-1:0]  job_win,
  output smf_ctl_t                             job_ctl
);

  localparam int HALF_MAX = (WINDOW_MAX - 1) / 2;
  localparam int FILL_W   = $clog2(WINDOW_MAX + 1);
  localparam int POS_W    = $clog2(LINE_MAX);
  localparam int CW       = (POS_W > INDEX_W) ? POS_W : INDEX_W;
  localparam int CMP_W    = 8;

  logic [HW_W-1:0]                     hw_r, hw_nxt;
  logic [FILL_W-1:0]                   fill_r, fill_nxt, fill_base;
  logic [POS_W-1:0]                    pos_r, pos_nxt, pos_cur;
  logic [POS_W:0]                      pos_inc;
  logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] win_r, win_nxt;
  logic [HW_W-1:0]                     h_eff;
  logic [CMP_W-1:0]                    len;
  logic                                accept;
  logic [CW-1:0]                       pos_x, h_x, diff;

  // clamp the configured half width to the supported range
  always_comb begin
    if (hw_r == '0) begin
      h_eff = HW_W'(1);
    end else if (int'(hw_r) > HALF_MAX) begin
      h_eff = HW_W'(HALF_MAX);
    end else begin
      h_eff = hw_r;
    end
  end

  assign len      = CMP_W'({h_eff, 1'b1});
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // window shift, fill count and position update
  always_comb begin
    fill_base = in_line_start ? '0 : fill_r;
    pos_cur   = in_line_start ? '0 : pos_r;
    pos_inc   = {1'b0, pos_cur} + (POS_W+1)'(1);
    win_nxt   = {win_r[WINDOW_MAX-2:0], in_sample};
    fill_nxt  = (int'(fill_base) < WINDOW_MAX) ? fill_base + FILL_W'(1) : fill_base;
    pos_nxt   = (pos_inc < (POS_W+1)'(LINE_MAX)) ? pos_inc[POS_W-1:0]
                                                 : POS_W'(LINE_MAX - 1);
    hw_nxt    = cfg_we ? cfg_wdata : hw_r;
  end

  // centre index: position minus half width, floored at zero
  always_comb begin
    pos_x = CW'(pos_cur);
    h_x   = CW'(h_eff);
    diff  = (pos_x >= h_x) ? pos_x - h_x : '0;
  end

  // a full window turns this transaction into a median job
  assign q_push         = accept && (CMP_W'(fill_nxt) >= len);
  assign job_win        = win_nxt;
  assign job_ctl.half   = h_eff;
  assign job_ctl.center = diff[INDEX_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r   <= HW_RESET;
      fill_r <= '0;
      pos_r  <= '0;
    end else begin
      hw_r <= hw_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  // window payload
  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

// File: src/smf_job_queue.sv
// smf_job_queue: short register queue decoupling the front and back parts
// depends on smf_pkg for the queue depth
module smf_job_queue import smf_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0][DATA_W-1:0] mem_r;
  logic [PTR_W-1:0]                   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                   count_r, count_nxt;

  assign full     = (int'(count_r) == QUEUE_DEPTH);
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("job queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("job queue count did not follow a lone write");

endmodule

// File: src/smf_back.sv
// smf_back: ranks the window of each job and picks the median, in two stages
// (comparison matrix, then rank count and select into the output register); uses smf_pkg
module smf_back import smf_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic [WINDOW_MAX-1:0][SAMPLE_W-1:0] job_win,
  input  smf_ctl_t                            job_ctl,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [SAMPLE_W-1:0]                 out_median,
  output logic [INDEX_W-1:0]                  out_center
);

  localparam int RK_W  = $clog2(WINDOW_MAX);
  localparam int CMP_W = 8;

  logic [WINDOW_MAX-1:0][WINDOW_MAX-1:0] lt_nxt, lt_r;
  logic [WINDOW_MAX-1:0]                 inwin_nxt, inwin_r;
  logic [WINDOW_MAX-1:0][SAMPLE_W-1:0]   s1_win_r;
  smf_ctl_t                              s1_ctl_r;
  logic                                  s1_v_r, s1_v_nxt;
  logic                                  out_v_r, out_v_nxt;
  logic [SAMPLE_W-1:0]                   med_nxt, med_r;
  logic [INDEX_W-1:0]                    ctr_r;
  logic                                  out_free, s1_adv, s1_free;

  // flow control through the two stages
  assign out_free = !out_v_r || out_ready;
  assign s1_adv   = s1_v_r && out_free;
  assign s1_free  = !s1_v_r || out_free;
  assign q_pop    = !q_empty && s1_free;

  always_comb begin
    s1_v_nxt  = q_pop ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  // stage 1: pairwise order with ties broken by age, and window membership
  always_comb begin
    for (int i = 0; i < WINDOW_MAX; i++) begin
      for (int j = 0; j < WINDOW_MAX; j++) begin
        lt_nxt[i][j] = (job_win[j] < job_win[i]) || ((job_win[j] == job_win[i]) && (j < i));
      end
      inwin_nxt[i] = (i <= 2 * int'(job_ctl.half));
    end
  end

  // stage 2: the member with exactly half-width smaller members is the median
  always_comb begin
    logic [RK_W-1:0] rank;
    med_nxt = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      rank = '0;
      for (int j = 0; j < WINDOW_MAX; j++) begin
        rank = rank + RK_W'(lt_r[i][j] && inwin_r[j]);
      end
      if (inwin_r[i] && (CMP_W'(rank) == CMP_W'(s1_ctl_r.half))) begin
        med_nxt = med_nxt | s1_win_r[i];
      end
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      lt_r     <= lt_nxt;
      inwin_r  <= inwin_nxt;
      s1_win_r <= job_win;
      s1_ctl_r <= job_ctl;
    end
    if (s1_adv) begin
      med_r <= med_nxt;
      ctr_r <= s1_ctl_r.center;
    end
  end

  assign out_valid  = out_v_r;
  assign out_median = med_r;
  assign out_center = ctr_r;

  // a blocked stage 1 keeps its job until the output register frees up
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> (s1_v_r && $stable(s1_ctl_r)))
    else $error("stage 1 job lost while output stalled");

endmodule
